// ===== design/trt_pkg.sv =====
// shared constants and register indexes of the triangle raster traversal unit
`default_nettype none

package trt_pkg;

    // default coordinate width in bits
    localparam int COORD_BITS_DEF = 10;
    // width of the fill colour
    localparam int COLOR_BITS = 24;
    // width of a configuration register index
    localparam int CFG_IDX_BITS = 3;
    // entries in the queue between walker and coverage pipeline
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VERT0_X    = 3'd0,
        REG_VERT0_Y    = 3'd1,
        REG_VERT1_X    = 3'd2,
        REG_VERT1_Y    = 3'd3,
        REG_VERT2_X    = 3'd4,
        REG_VERT2_Y    = 3'd5,
        REG_FILL_COLOR = 3'd6
    } cfg_reg_t;

endpackage : trt_pkg

`default_nettype wire

// ===== design/trt_front.sv =====
// walker: keeps the bounding box and steps the pixel position per beat
`default_nettype none

module trt_front
    import trt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic                  in_restart,
    output logic                       in_ready,
    input  wire logic [COORD_BITS-1:0] v0_x,
    input  wire logic [COORD_BITS-1:0] v0_y,
    input  wire logic [COORD_BITS-1:0] v1_x,
    input  wire logic [COORD_BITS-1:0] v1_y,
    input  wire logic [COORD_BITS-1:0] v2_x,
    input  wire logic [COORD_BITS-1:0] v2_y,
    output logic                       q_push,
    output logic [2*COORD_BITS:0]      q_data,
    input  wire logic                  q_ready
);

    logic [COORD_BITS-1:0] box_min_x_reg, box_min_x_next;
    logic [COORD_BITS-1:0] box_min_y_reg, box_min_y_next;
    logic [COORD_BITS-1:0] box_max_x_reg, box_max_x_next;
    logic [COORD_BITS-1:0] box_max_y_reg, box_max_y_next;
    logic [COORD_BITS-1:0] walk_x_reg, walk_x_next;
    logic [COORD_BITS-1:0] walk_y_reg, walk_y_next;
    logic [COORD_BITS-1:0] mn_x01, mn_y01, mx_x01, mx_y01;
    logic                  last_flag;
    logic                  accept;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;

    always_comb begin
        mn_x01 = (v0_x < v1_x) ? v0_x : v1_x;
        mx_x01 = (v0_x > v1_x) ? v0_x : v1_x;
        mn_y01 = (v0_y < v1_y) ? v0_y : v1_y;
        mx_y01 = (v0_y > v1_y) ? v0_y : v1_y;

        box_min_x_next = box_min_x_reg;
        box_min_y_next = box_min_y_reg;
        box_max_x_next = box_max_x_reg;
        box_max_y_next = box_max_y_reg;
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;

        if (in_restart) begin
            box_min_x_next = (mn_x01 < v2_x) ? mn_x01 : v2_x;
            box_max_x_next = (mx_x01 > v2_x) ? mx_x01 : v2_x;
            box_min_y_next = (mn_y01 < v2_y) ? mn_y01 : v2_y;
            box_max_y_next = (mx_y01 > v2_y) ? mx_y01 : v2_y;
            walk_x_next    = box_min_x_next;
            walk_y_next    = box_min_y_next;
        end else if (walk_x_reg < box_max_x_reg) begin
            walk_x_next = walk_x_reg + 1'b1;
        end else begin
            walk_x_next = box_min_x_reg;
            if (walk_y_reg < box_max_y_reg) begin
                walk_y_next = walk_y_reg + 1'b1;
            end else begin
                walk_y_next = box_min_y_reg;
            end
        end

        last_flag = (walk_x_next == box_max_x_next) && (walk_y_next == box_max_y_next);
    end

    assign q_push = accept;
    assign q_data = {last_flag, walk_y_next, walk_x_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_min_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
        end else if (accept) begin
            box_min_x_reg <= box_min_x_next;
            box_min_y_reg <= box_min_y_next;
            box_max_x_reg <= box_max_x_next;
            box_max_y_reg <= box_max_y_next;
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
        end
    end

endmodule : trt_front

`default_nettype wire

// ===== design/trt_queue.sv =====
// small flop queue between walker and coverage pipeline
`default_nettype none

module trt_queue
    import trt_pkg::*;
#(
    parameter int WIDTH = 2 * COORD_BITS_DEF + 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  wr_ready,
    output logic                  rd_valid,
    output logic [WIDTH-1:0]      rd_data,
    input  wire logic             rd_pop
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule : trt_queue

`default_nettype wire

// ===== design/trt_back.sv =====
// coverage pipeline: edge products, numerators, sign test, output register
`default_nettype none

module trt_back
    import trt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_valid,
    input  wire logic [2*COORD_BITS:0] q_data,
    output logic                       q_pop,
    input  wire logic [COORD_BITS-1:0] v0_x,
    input  wire logic [COORD_BITS-1:0] v0_y,
    input  wire logic [COORD_BITS-1:0] v1_x,
    input  wire logic [COORD_BITS-1:0] v1_y,
    input  wire logic [COORD_BITS-1:0] v2_x,
    input  wire logic [COORD_BITS-1:0] v2_y,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [COORD_BITS-1:0]      out_x,
    output logic [COORD_BITS-1:0]      out_y,
    output logic                       out_covered,
    output logic                       out_last
);

    localparam int DW = COORD_BITS + 1;   // vertex differences
    localparam int PW = 2 * DW;           // one product
    localparam int NW = PW + 1;           // difference of two products
    localparam int WW = NW + 2;           // d - ux - uy

    logic                  en;
    logic [COORD_BITS-1:0] px, py;
    logic                  plast;
    logic signed [DW-1:0]  abx, aby, acx, acy, pax, pay;

    // stage 1: products
    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic                  s1_last_reg;
    logic signed [PW-1:0]  m_acx_pay_reg, m_pax_acy_reg, m_pax_aby_reg;
    logic signed [PW-1:0]  m_abx_pay_reg, m_abx_acy_reg, m_acx_aby_reg;

    // stage 2: numerators
    logic                  s2_valid_reg;
    logic [COORD_BITS-1:0] s2_x_reg, s2_y_reg;
    logic                  s2_last_reg;
    logic signed [NW-1:0]  ux_reg, uy_reg, d_reg;

    // stage 3: sign test
    logic signed [WW-1:0]  w_val;
    logic                  d_pos, cov_next;
    logic                  o_valid_reg, o_cov_reg, o_last_reg;
    logic [COORD_BITS-1:0] o_x_reg, o_y_reg;

    function automatic logic agrees(input logic signed [WW-1:0] v, input logic dp);
        agrees = (v == '0) || ((!v[WW-1]) == dp);
    endfunction

    // whole pipeline advances unless the output beat is stalled
    assign en    = !o_valid_reg || out_ready;
    assign q_pop = en && q_valid;

    assign px    = q_data[COORD_BITS-1:0];
    assign py    = q_data[2*COORD_BITS-1:COORD_BITS];
    assign plast = q_data[2*COORD_BITS];

    assign abx = $signed({1'b0, v1_x}) - $signed({1'b0, v0_x});
    assign aby = $signed({1'b0, v1_y}) - $signed({1'b0, v0_y});
    assign acx = $signed({1'b0, v2_x}) - $signed({1'b0, v0_x});
    assign acy = $signed({1'b0, v2_y}) - $signed({1'b0, v0_y});
    assign pax = $signed({1'b0, v0_x}) - $signed({1'b0, px});
    assign pay = $signed({1'b0, v0_y}) - $signed({1'b0, py});

    always_comb begin
        w_val    = WW'(d_reg) - WW'(ux_reg) - WW'(uy_reg);
        d_pos    = !d_reg[NW-1] && (d_reg != '0);
        cov_next = (d_reg != '0) && agrees(WW'(ux_reg), d_pos)
                   && agrees(WW'(uy_reg), d_pos) && agrees(w_val, d_pos);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            o_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg      <= px;
            s1_y_reg      <= py;
            s1_last_reg   <= plast;
            m_acx_pay_reg <= acx * pay;
            m_pax_acy_reg <= pax * acy;
            m_pax_aby_reg <= pax * aby;
            m_abx_pay_reg <= abx * pay;
            m_abx_acy_reg <= abx * acy;
            m_acx_aby_reg <= acx * aby;

            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_last_reg <= s1_last_reg;
            ux_reg      <= NW'(m_acx_pay_reg) - NW'(m_pax_acy_reg);
            uy_reg      <= NW'(m_pax_aby_reg) - NW'(m_abx_pay_reg);
            d_reg       <= NW'(m_abx_acy_reg) - NW'(m_acx_aby_reg);

            o_x_reg    <= s2_x_reg;
            o_y_reg    <= s2_y_reg;
            o_last_reg <= s2_last_reg;
            o_cov_reg  <= cov_next;
        end
    end

    assign out_valid   = o_valid_reg;
    assign out_x       = o_x_reg;
    assign out_y       = o_y_reg;
    assign out_covered = o_cov_reg;
    assign out_last    = o_last_reg;

endmodule : trt_back

`default_nettype wire

// ===== design/triangle_raster_traversal_unit.sv =====
// top level of the triangle raster traversal unit: config registers, walker, queue, coverage
//
//   channel  ports                          direction  beat
//   s_       s_valid s_ready s_restart      in         one walk step or restart
//   m_       m_valid m_ready m_pixel_*      out        one visited pixel
//   cfg_     cfg_valid cfg_ready cfg_index  in         one register write
//            cfg_data
//
// one pixel per cycle while m_ready is high; each input beat gives exactly one output beat
// m_valid rises after an accepted beat has passed the queue slot, product stage,
// numerator stage and output register
// the walker runs ahead into a four-entry queue while the output stalls
// aresetn is synchronous, active low; clears box, walk, config, queue pointers, valid bits
// cfg_ready is always high; each write goes straight into its register
`default_nettype none

module triangle_raster_traversal_unit
    import trt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // walk request channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_restart,
    // pixel channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [COORD_BITS-1:0]        m_pixel_x,
    output logic [COORD_BITS-1:0]        m_pixel_y,
    output logic                         m_covered,
    output logic [COLOR_BITS-1:0]        m_pixel_color,
    output logic                         m_last_pixel,
    // configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [COLOR_BITS-1:0]   cfg_data
);

    localparam int QW = 2 * COORD_BITS + 1;   // queue entry: last, y, x

    // vertex and colour registers
    logic [COORD_BITS-1:0] v0_x_reg, v0_y_reg, v1_x_reg, v1_y_reg, v2_x_reg, v2_y_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic [COORD_BITS-1:0] cfg_coord;

    // walker to queue
    logic          f_push, f_ready;
    logic [QW-1:0] f_data;

    // queue to coverage
    logic          q_valid, q_pop;
    logic [QW-1:0] q_data;

    assign cfg_ready = 1'b1;
    assign cfg_coord = cfg_data[COORD_BITS-1:0];

    // register file; out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_x_reg  <= '0;
            v0_y_reg  <= '0;
            v1_x_reg  <= '0;
            v1_y_reg  <= '0;
            v2_x_reg  <= '0;
            v2_y_reg  <= '0;
            color_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_VERT0_X:    v0_x_reg  <= cfg_coord;
                REG_VERT0_Y:    v0_y_reg  <= cfg_coord;
                REG_VERT1_X:    v1_x_reg  <= cfg_coord;
                REG_VERT1_Y:    v1_y_reg  <= cfg_coord;
                REG_VERT2_X:    v2_x_reg  <= cfg_coord;
                REG_VERT2_Y:    v2_y_reg  <= cfg_coord;
                REG_FILL_COLOR: color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: box latch and pixel stepping
    trt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_restart (s_restart),
        .in_ready   (s_ready),
        .v0_x       (v0_x_reg),
        .v0_y       (v0_y_reg),
        .v1_x       (v1_x_reg),
        .v1_y       (v1_y_reg),
        .v2_x       (v2_x_reg),
        .v2_y       (v2_y_reg),
        .q_push     (f_push),
        .q_data     (f_data),
        .q_ready    (f_ready)
    );

    // decoupling queue
    trt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_push),
        .wr_data  (f_data),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_data  (q_data),
        .rd_pop   (q_pop)
    );

    // back: barycentric coverage test
    trt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .v0_x        (v0_x_reg),
        .v0_y        (v0_y_reg),
        .v1_x        (v1_x_reg),
        .v1_y        (v1_y_reg),
        .v2_x        (v2_x_reg),
        .v2_y        (v2_y_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_x       (m_pixel_x),
        .out_y       (m_pixel_y),
        .out_covered (m_covered),
        .out_last    (m_last_pixel)
    );

    // the user must change colour registers only while the unit is idle; not enforced
    assign m_pixel_color = color_reg;

endmodule : triangle_raster_traversal_unit

`default_nettype wire
